// ===== src/fpa_pkg.sv =====
`timescale 1ns / 1ps
package fpa_pkg;

	localparam int FracBitsDefault = 8;
	localparam int DataWidth = 32;
	// Dividend magnitude is |a| << FRAC_BITS, at most 32 + FRAC_BITS bits.
	localparam int NumWidth = 64;
	localparam int MagWidth = 33;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MIN = 3'd4,
		OP_MAX = 3'd5,
		OP_INC = 3'd6,
		OP_DEC = 3'd7
	} op_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] result_raw;
		logic               a_greater;
		logic               a_less;
		logic               a_equal;
		logic               overflow;
		logic               divide_by_zero;
	} out_beat_t;

	// Everything a cell hands to its right-hand neighbor.
	typedef struct packed {
		logic                 vld;
		logic [2:0]           op;
		logic signed [31:0]   a;
		logic signed [31:0]   b;
		logic [NumWidth-1:0]  rem;   // partial remainder
		logic [NumWidth-1:0]  quo;   // numerator bits shifting out, quotient in
		logic [MagWidth-1:0]  den;   // divisor magnitude
		logic [NumWidth-1:0]  prod;  // product magnitude, from the multiplier
	} cell_data_t;

	function automatic logic signed [31:0] sat64(input logic signed [65:0] v,
			output logic ovf);
		logic signed [65:0] mx;
		logic signed [65:0] mn;
		begin
			mx = 66'sd2147483647;
			mn = -66'sd2147483648;
			ovf = 1'b0;
			if (v > mx) begin
				ovf = 1'b1;
				sat64 = 32'sh7fffffff;
			end else if (v < mn) begin
				ovf = 1'b1;
				sat64 = 32'sh80000000;
			end else begin
				sat64 = v[31:0];
			end
		end
	endfunction

endpackage

// ===== src/fpa_div_cell.sv =====
`timescale 1ns / 1ps
module fpa_div_cell
	import fpa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  cell_data_t din,
	output cell_data_t dout
);

	// One restoring-division step: shift the next numerator bit into the
	// partial remainder, trial subtract, keep the quotient bit.
	cell_data_t nxt;
	logic [NumWidth:0] shifted;
	logic [NumWidth:0] diff;
	logic              qbit;

	always_comb begin
		shifted = {din.rem, din.quo[NumWidth-1]};
		diff = shifted - {{(NumWidth+1-MagWidth){1'b0}}, din.den};
		qbit = ~diff[NumWidth];
		nxt = din;
		nxt.rem = qbit ? diff[NumWidth-1:0] : shifted[NumWidth-1:0];
		nxt.quo = {din.quo[NumWidth-2:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (adv) begin
			dout <= nxt;
		end
	end

endmodule

// ===== src/fpa_finish.sv =====
`timescale 1ns / 1ps
module fpa_finish
	import fpa_pkg::*;
#(
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  cell_data_t din,
	output out_beat_t  res
);

	logic signed [65:0] a_x;
	logic signed [65:0] b_x;
	logic signed [65:0] val;
	logic               neg;
	logic [NumWidth:0]  m;
	logic [NumWidth:0]  twice_rem;
	logic               ovf;
	logic               dbz;
	logic signed [31:0] r;

	always_comb begin
		a_x = 66'(din.a);
		b_x = 66'(din.b);
		neg = din.a[31] ^ din.b[31];
		dbz = 1'b0;
		val = '0;
		m = '0;
		twice_rem = {din.rem, 1'b0};
		case (din.op)
			OP_ADD: val = a_x + b_x;
			OP_SUB: val = a_x - b_x;
			OP_MUL: begin
				m = ({1'b0, din.prod} + ((NumWidth+1)'(1) << FRAC_BITS >> 1))
					>> FRAC_BITS;
				val = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
			end
			OP_DIV: begin
				if (din.b == '0) begin
					dbz = 1'b1;
				end else begin
					m = {1'b0, din.quo};
					if (twice_rem >= {{(NumWidth+1-MagWidth){1'b0}}, din.den})
						m = m + 1'b1;
					val = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
				end
			end
			OP_MIN: val = (din.a < din.b) ? a_x : b_x;
			OP_MAX: val = (din.a > din.b) ? a_x : b_x;
			OP_INC: val = a_x + 66'sd1;
			default: val = a_x - 66'sd1;
		endcase
		r = sat64(val, ovf);
		res.result_raw = r;
		res.a_greater = din.a > din.b;
		res.a_less = din.a < din.b;
		res.a_equal = din.a == din.b;
		res.overflow = ovf;
		res.divide_by_zero = dbz;
	end

endmodule

// ===== src/fixed_point_alu_unit.sv =====
`timescale 1ns / 1ps
// Channel | Valid     | Stall     | Payload
// input   | valid     | stall     | in_beat  (in_beat_t: op, operand_a, operand_b)
// output  | res_valid | res_stall | out_beat (out_beat_t: result_raw and flags)
// One beat enters per cycle unless the output stalls; each beat passes the
// head stage, the division cells (a quotient bit each) and the output register.
// A multiply uses one registered 33x33 stage ahead of the row.
// Reset clears the head stage, the row and the output valid bit.
// An output stall freezes the whole row, so the input stalls with it.
module fixed_point_alu_unit
	import fpa_pkg::*;
#(
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid,
	output logic      stall,
	input  in_beat_t  in_beat,
	output logic      res_valid,
	input  logic      res_stall,
	output out_beat_t out_beat
);

	localparam int Cells = NumWidth;

	// The row advances whenever the output register is free or being emptied.
	logic adv;
	assign adv = !res_valid || !res_stall;
	assign stall = !adv;

	cell_data_t head_s1;
	cell_data_t row [Cells+1];
	logic [MagWidth-1:0] mag_a;
	logic [MagWidth-1:0] mag_b;
	logic [2*MagWidth-1:0] prod;

	// First stage: take magnitudes, form the product and the numerator.
	always_comb begin
		mag_a = in_beat.operand_a[31] ? MagWidth'(-33'(in_beat.operand_a))
			: MagWidth'(in_beat.operand_a);
		mag_b = in_beat.operand_b[31] ? MagWidth'(-33'(in_beat.operand_b))
			: MagWidth'(in_beat.operand_b);
		prod = mag_a * mag_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_s1 <= '0;
		end else if (adv) begin
			head_s1.vld <= valid;
			head_s1.op <= in_beat.op;
			head_s1.a <= in_beat.operand_a;
			head_s1.b <= in_beat.operand_b;
			head_s1.rem <= '0;
			head_s1.quo <= NumWidth'(mag_a) << FRAC_BITS;
			head_s1.den <= mag_b;
			head_s1.prod <= prod[NumWidth-1:0];
		end
	end

	assign row[0] = head_s1;

	for (genvar i = 0; i < Cells; i++) begin : g_cell
		fpa_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.din(row[i]),
			.dout(row[i+1])
		);
	end

	out_beat_t fin;
	fpa_finish #(.FRAC_BITS(FRAC_BITS)) u_finish (
		.din(row[Cells]),
		.res(fin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= row[Cells].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_beat <= fin;
		end
	end

	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot({out_beat.a_greater, out_beat.a_less, out_beat.a_equal}))
		else $error("compare flags not one-hot");
	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_beat.divide_by_zero |-> out_beat.result_raw == '0
		&& !out_beat.overflow)
		else $error("divide by zero with nonzero result");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_beat))
		else $error("output changed under stall");

endmodule

// ===== bench/tb_fixed_point_alu_unit.sv =====
`timescale 1ns / 1ps
module tb_fixed_point_alu_unit;
	import fpa_pkg::*;

	localparam int Frac = FracBitsDefault;
	// The row of division cells sets the latency of the block.
	localparam int PipeDepth = NumWidth + 1;
	localparam int NumRandom = 1530;
	localparam longint CycleLimit = 400000;

	// Predicts one result beat from one input beat with exact integer arithmetic.
	function automatic out_beat_t alu_predict(in_beat_t ib);
		out_beat_t res;
		longint a, b, v, lo, hi;
		longint unsigned ma, mb, m, q, r;
		bit neg;
		a = longint'(ib.operand_a);
		b = longint'(ib.operand_b);
		lo = -64'sd2147483648;
		hi = 64'sd2147483647;
		v = 0;
		res = '0;
		neg = (a < 0) != (b < 0);
		ma = a < 0 ? longint'(-a) : a;
		mb = b < 0 ? longint'(-b) : b;
		case (op_t'(ib.op))
			OP_ADD: v = a + b;
			OP_SUB: v = a - b;
			OP_MUL: begin
				m = (ma * mb + ((64'd1 << Frac) >> 1)) >> Frac;
				v = neg ? -longint'(m) : longint'(m);
			end
			OP_DIV: begin
				if (b == 0) begin
					res.divide_by_zero = 1'b1;
				end else begin
					q = (ma << Frac) / mb;
					r = (ma << Frac) % mb;
					if (r * 2 >= mb)
						q++;
					v = neg ? -longint'(q) : longint'(q);
				end
			end
			OP_MIN: v = a < b ? a : b;
			OP_MAX: v = a > b ? a : b;
			OP_INC: v = a + 1;
			default: v = a - 1;
		endcase
		if (v > hi) begin
			v = hi;
			res.overflow = 1'b1;
		end else if (v < lo) begin
			v = lo;
			res.overflow = 1'b1;
		end
		res.result_raw = v[31:0];
		res.a_greater = a > b;
		res.a_less = a < b;
		res.a_equal = a == b;
		return res;
	endfunction

	int errors = 0;

	// Every mismatch goes through here: each is counted, the first 40 printed as one line each.
	task automatic report(string msg);
		errors++;
		if (errors <= 40)
			$display("%0t mismatch: %s", $realtime, msg);
	endtask

	// Keeps the results still owed by the block, oldest first.
	class alu_scoreboard;
		out_beat_t owed[$];
		int checked = 0;

		function void note_input(in_beat_t ib);
			owed.push_back(alu_predict(ib));
		endfunction

		task check_result(out_beat_t got);
			out_beat_t exp;
			if (owed.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			exp = owed.pop_front();
			checked++;
			if (got.result_raw !== exp.result_raw)
				report($sformatf("result_raw %h, expected %h", got.result_raw,
					exp.result_raw));
			if (got.a_greater !== exp.a_greater)
				report("a_greater differs");
			if (got.a_less !== exp.a_less)
				report("a_less differs");
			if (got.a_equal !== exp.a_equal)
				report("a_equal differs");
			if (got.overflow !== exp.overflow)
				report("overflow differs");
			if (got.divide_by_zero !== exp.divide_by_zero)
				report("divide_by_zero differs");
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid = 1'b0;
	logic stall;
	in_beat_t in_beat = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	out_beat_t out_beat;

	alu_scoreboard board = new();
	longint cycles = 0;
	// While set, both sides keep their handshakes running with no idle cycles.
	bit steady = 1'b0;
	// While set, the receiver holds off entirely so the pipeline backs up.
	bit hold_off = 1'b0;

	always #5 clk = ~clk;

	fixed_point_alu_unit #(.FRAC_BITS(Frac)) dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall),
		.in_beat(in_beat), .res_valid(res_valid), .res_stall(res_stall),
		.out_beat(out_beat)
	);

	// The cycle counter ends a run that hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Results are sampled at the edge, before the bench updates res_stall, so
	// the beat counted is the one the block also considers accepted.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			board.check_result(out_beat);
	end

	// The receiver stalls about a quarter of the time, except in the steady
	// stretch, and holds off completely while the pressure phase asks for it.
	always @(posedge clk) begin
		if (hold_off)
			res_stall <= 1'b1;
		else if (steady)
			res_stall <= 1'b0;
		else
			res_stall <= ($urandom_range(99) < 24);
	end

	// Sends one beat: holds valid and payload until a cycle with no stall.
	// The sender may idle first, which puts gaps at every pipeline phase.
	task automatic send_beat(in_beat_t ib);
		if (!steady) begin
			while ($urandom_range(99) < 24) begin
				valid <= 1'b0;
				@(posedge clk);
			end
		end
		valid <= 1'b1;
		in_beat <= ib;
		@(posedge clk);
		while (stall)
			@(posedge clk);
		board.note_input(ib);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'(int'($urandom_range(8)) - 4);
			3: return 32'($urandom_range(4095)) << $urandom_range(20);
			4: return -(32'($urandom_range(65535)));
			5: return 32'($urandom_range(1023));
			default: return $urandom();
		endcase
	endfunction

	task automatic send_random();
		in_beat_t ib;
		ib.op = 3'($urandom_range(7));
		ib.operand_a = pick_operand();
		ib.operand_b = ($urandom_range(15) == 0) ? 32'(ib.operand_a) : pick_operand();
		// Division by zero shows up now and then.
		if (ib.op == OP_DIV && $urandom_range(9) == 0)
			ib.operand_b = '0;
		send_beat(ib);
	endtask

	// Directed beats: field extremes, each operation, and the special cases.
	task automatic send_directed();
		in_beat_t ib;
		logic [31:0] vals[6];
		vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h00000100,
			32'h00000180};
		for (int o = 0; o < 8; o++) begin
			ib.op = o[2:0];
			ib.operand_a = vals[o % 6];
			ib.operand_b = vals[(o + 3) % 6];
			send_beat(ib);
		end
		// Saturation at both limits for add, subtract, increment, decrement.
		send_beat('{OP_ADD, 32'sh7fffffff, 32'sh1});
		send_beat('{OP_SUB, 32'sh80000000, 32'sh1});
		send_beat('{OP_INC, 32'sh7fffffff, 32'sh0});
		send_beat('{OP_DEC, 32'sh80000000, 32'sh7fffffff});
		// Multiply overflow and rounding of a half toward larger magnitude.
		send_beat('{OP_MUL, 32'sh80000000, 32'sh80000000});
		send_beat('{OP_MUL, 32'sh00000180, 32'sh00000001});
		send_beat('{OP_MUL, -32'sh00000180, 32'sh00000001});
		// Division by zero, divide overflow, and a halfway quotient.
		send_beat('{OP_DIV, 32'sh12345678, 32'sh0});
		send_beat('{OP_DIV, 32'sh80000000, 32'sh00000001});
		send_beat('{OP_DIV, 32'sh00000001, 32'sh00000200});
		send_beat('{OP_DIV, -32'sh00000001, 32'sh00000200});
		send_beat('{OP_DIV, 32'sh80000000, 32'shffffffff});
		// Min and max with equal operands give the same value either way; then max of the extremes.
		send_beat('{OP_MIN, 32'sh00000055, 32'sh00000055});
		send_beat('{OP_MAX, -32'sh00000055, -32'sh00000055});
		send_beat('{OP_MAX, 32'sh80000000, 32'sh7fffffff});
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		for (int i = 0; i < NumRandom; i++) begin
			// A steady stretch with no idling on either side.
			steady = (i >= 300 && i < 500);
			// The receiver holds off for a long stretch while beats keep coming.
			if (i == 700)
				fork
					begin
						hold_off = 1'b1;
						repeat (3 * PipeDepth) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			send_random();
		end
		valid <= 1'b0;
		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (PipeDepth + 4) @(posedge clk);
		$display("Covered %0d beats over all eight operations, including", board.checked);
		$display("saturation, rounding, division by zero and a long output stall.");
		if (errors == 0 && board.owed.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
src/fpa_pkg.sv
src/fpa_div_cell.sv
src/fpa_finish.sv
src/fixed_point_alu_unit.sv
bench/tb_fixed_point_alu_unit.sv
